/* design/bdrl_pkg.sv */
// Shared types and constants for the button debounce / repeat / long-press block.
// Holds the input and result transaction structs, field widths and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bdrl_pkg;

    localparam int PIN_W    = 8;
    localparam int PIN_BITS = 8;
    localparam int TIME_W   = 32;
    localparam int STAMP_W  = 64;
    localparam int EN_W     = 3;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // Pin bits that may belong to the button at all
    localparam logic [PIN_W-1:0] PIN_USED_MASK =
        (PIN_BITS >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((1 << PIN_BITS) - 1);

    localparam logic [TIME_W-1:0] NEVER_TICKS = {TIME_W{1'b1}};

    // Bit positions in event_enables
    localparam int EN_SHORT  = 0;
    localparam int EN_LONG   = 1;
    localparam int EN_LONGUP = 2;

    typedef enum logic [2:0] {
        REG_PIN_MASK   = 3'd0,
        REG_DEBOUNCE   = 3'd1,
        REG_REPEAT     = 3'd2,
        REG_LONG_PRESS = 3'd3,
        REG_ENABLES    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [PIN_W-1:0]   pin_levels;
        logic [STAMP_W-1:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic              short_press;
        logic              repeat_fire;
        logic              long_start;
        logic              long_release;
        logic [TIME_W-1:0] wait_ticks;
    } out_item_t;

endpackage

/* design/bdrl_serial_mul.sv */
// Bit-serial shift-add multiplier, product kept modulo 2^WIDTH.
// One multiplier bit per cycle. Depends on bdrl_pkg.
`timescale 1ns / 1ps

module bdrl_serial_mul import bdrl_pkg::*; #(
    parameter int WIDTH = TIME_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] mcand,
    input  logic [WIDTH-1:0] mplier,
    output logic             done,
    output logic [WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] mcand_reg;
    logic [WIDTH-1:0] mplier_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Add the shifted multiplicand when the current multiplier bit is set
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= '0;
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[WIDTH-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[WIDTH-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* design/bdrl_serial_div.sv */
// Restoring radix-2 divider that returns the remainder only.
// One dividend bit per cycle. Depends on bdrl_pkg.
`timescale 1ns / 1ps

module bdrl_serial_div import bdrl_pkg::*; #(
    parameter int WIDTH = TIME_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] dvd_reg;
    logic [WIDTH-1:0] dvs_reg;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, dvd_reg[WIDTH-1]};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Shift in one dividend bit, subtract the divisor where it fits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* design/button_debounce_repeat_longpress.sv */
// Button debouncer with autorepeat and long-press detection, top level.
// Uses bdrl_pkg, bdrl_serial_mul and bdrl_serial_div.
//
// Usage:
//   s_ channel: one transaction per pin sample (pin_levels, time_now). Only the
//   low 32 bits of time_now are used; elapsed times wrap modulo 2^32.
//   m_ channel: exactly one result transaction per sample: short_press,
//   repeat_fire, long_start, long_release flags and wait_ticks, the ticks
//   until the next sample is needed (all ones = never).
//   APB port: five registers at byte addresses 0,4,8,12,16 (pin_mask,
//   debounce_time, repeat_interval, long_press_time, event_enables); write
//   them only while the block is idle. pready is always high.
// Timing:
//   One sample at a time. From acceptance to its result in the output
//   register a sample goes through these steps: update the level, form the
//   elapsed time, run the bit-serial multiplier (repeat_count *
//   repeat_interval) and the bit-serial divider (elapsed % repeat_interval)
//   side by side, evaluate events, load the result.
//   s_ready is high only while no sample is in flight, so a new sample
//   enters in the cycle after the previous result is loaded.
// Reset (aresetn low, synchronous): registers return to their defaults, the
//   button goes to its power-on state and the output register empties.
// Stall: while m_ready is low the result holds in the output register; a
//   following sample is still accepted and worked on, and waits for the
//   output register to empty before its own result is loaded.
`timescale 1ns / 1ps

module button_debounce_repeat_longpress import bdrl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // sample channel
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        LVL_POWERON = 2'd0,
        LVL_UP      = 2'd1,
        LVL_DOWN    = 2'd2
    } level_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_RUN,
        S_EVAL,
        S_NOTIFY
    } state_t;

    // Configuration registers
    logic [PIN_W-1:0]  pin_mask_reg;
    logic [TIME_W-1:0] debounce_reg;
    logic [TIME_W-1:0] repeat_reg;
    logic [TIME_W-1:0] long_press_reg;
    logic [EN_W-1:0]   enables_reg;

    // Button state
    state_t            state_reg;
    level_t            level_reg;
    logic [TIME_W-1:0] change_time_reg;
    logic              pending_reg;
    logic              long_active_reg;
    logic [TIME_W-1:0] repeat_count_reg;

    // Per-sample working registers
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] delta_reg;
    logic              complete_reg;
    out_item_t         res_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    // Combinational helpers
    logic              s_fire;
    logic              cfg_write;
    level_t            lvl_in;
    logic              lvl_change;
    logic [TIME_W-1:0] delta;
    logic              complete;
    logic              unit_start;
    logic [TIME_W-1:0] dividend;
    logic              mul_done;
    logic              div_done;
    logic [TIME_W-1:0] product;
    logic [TIME_W-1:0] rem;
    logic              held;
    logic              rep_hit;
    logic              long_hit;
    logic              short_ev;
    logic              longup_ev;
    logic              pending_after;
    logic              long_after;
    logic [TIME_W-1:0] delta2;
    logic [TIME_W-1:0] rep_phase;
    logic [TIME_W-1:0] wait_ticks;
    logic              out_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_valid_reg || m_ready;

    // Level seen in this sample; an up level at power-on is not a change
    always_comb begin
        lvl_in     = |(s_data.pin_levels & pin_mask_reg & PIN_USED_MASK) ? LVL_DOWN : LVL_UP;
        lvl_change = !(lvl_in == level_reg ||
                       (level_reg == LVL_POWERON && lvl_in == LVL_UP));
    end

    // Elapsed time; a completed debounce restarts it at zero for the modulo
    always_comb begin
        delta      = now_reg - change_time_reg;
        complete   = pending_reg && (delta >= debounce_reg);
        dividend   = complete ? '0 : delta;
        unit_start = (state_reg == S_DELTA);
    end

    bdrl_serial_mul #(
        .WIDTH (TIME_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .mcand   (repeat_reg),
        .mplier  (repeat_count_reg),
        .done    (mul_done),
        .product (product)
    );

    bdrl_serial_div #(
        .WIDTH (TIME_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (unit_start),
        .dividend  (dividend),
        .divisor   (repeat_reg),
        .done      (div_done),
        .remainder (rem)
    );

    // Event decisions and next wait, all from registered values
    always_comb begin
        held      = !pending_reg && (level_reg == LVL_DOWN);
        rep_phase = delta_reg - product;
        rep_hit   = held && (repeat_reg != NEVER_TICKS) && enables_reg[EN_SHORT] &&
                    (rep_phase >= repeat_reg);
        long_hit  = held && (long_press_reg != NEVER_TICKS) &&
                    (delta_reg >= long_press_reg) && !long_active_reg &&
                    enables_reg[EN_LONG];
        short_ev  = complete_reg && (level_reg == LVL_UP) && !long_active_reg &&
                    (repeat_count_reg == '0) && enables_reg[EN_SHORT];
        longup_ev = complete_reg && (level_reg == LVL_UP) && long_active_reg &&
                    enables_reg[EN_LONGUP];

        pending_after = pending_reg && !complete_reg;
        long_after    = (complete_reg && level_reg == LVL_DOWN) ? 1'b0
                                                                : (long_active_reg || long_hit);
        delta2        = complete_reg ? '0 : delta_reg;

        priority if (pending_after) begin
            wait_ticks = (debounce_reg > delta_reg) ? debounce_reg - delta_reg : '0;
        end else if (level_reg == LVL_DOWN && repeat_reg != NEVER_TICKS) begin
            wait_ticks = (repeat_reg == '0) ? '0 : repeat_reg - rem;
        end else if (level_reg == LVL_DOWN && !long_after && enables_reg[EN_LONG] &&
                     long_press_reg != NEVER_TICKS) begin
            wait_ticks = (long_press_reg > delta2) ? long_press_reg - delta2 : '0;
        end else begin
            wait_ticks = NEVER_TICKS;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_mask_reg   <= PIN_W'(1);
            debounce_reg   <= TIME_W'(50);
            repeat_reg     <= NEVER_TICKS;
            long_press_reg <= NEVER_TICKS;
            enables_reg    <= EN_W'(1);
        end else if (cfg_write) begin
            case (paddr[APB_AW-1:2])
                REG_PIN_MASK:   pin_mask_reg   <= pwdata[PIN_W-1:0];
                REG_DEBOUNCE:   debounce_reg   <= pwdata[TIME_W-1:0];
                REG_REPEAT:     repeat_reg     <= pwdata[TIME_W-1:0];
                REG_LONG_PRESS: long_press_reg <= pwdata[TIME_W-1:0];
                REG_ENABLES:    enables_reg    <= pwdata[EN_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_PIN_MASK:   prdata = APB_DW'(pin_mask_reg);
            REG_DEBOUNCE:   prdata = APB_DW'(debounce_reg);
            REG_REPEAT:     prdata = APB_DW'(repeat_reg);
            REG_LONG_PRESS: prdata = APB_DW'(long_press_reg);
            REG_ENABLES:    prdata = APB_DW'(enables_reg);
            default:        prdata = '0;
        endcase
    end

    // Sequencer, button state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            level_reg        <= LVL_POWERON;
            change_time_reg  <= '0;
            pending_reg      <= 1'b0;
            long_active_reg  <= 1'b0;
            repeat_count_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            // drop the result once the receiver takes it, unless the next one loads now
            if (m_valid_reg && m_ready && state_reg != S_NOTIFY) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        now_reg <= s_data.time_now[TIME_W-1:0];
                        // start a debounce on a real level change
                        if (lvl_change) begin
                            level_reg       <= lvl_in;
                            change_time_reg <= s_data.time_now[TIME_W-1:0];
                            pending_reg     <= 1'b1;
                        end
                        state_reg <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    delta_reg    <= delta;
                    complete_reg <= complete;
                    state_reg    <= S_RUN;
                end
                S_RUN: begin
                    // hold until product and remainder are both ready
                    if (mul_done && div_done) begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    res_reg.short_press  <= short_ev;
                    res_reg.repeat_fire  <= rep_hit;
                    res_reg.long_start   <= long_hit;
                    res_reg.long_release <= longup_ev;
                    res_reg.wait_ticks   <= wait_ticks;
                    if (complete_reg) begin
                        pending_reg     <= 1'b0;
                        change_time_reg <= now_reg;
                        if (level_reg == LVL_DOWN) begin
                            long_active_reg  <= 1'b0;
                            repeat_count_reg <= '0;
                        end
                    end else begin
                        if (rep_hit) begin
                            repeat_count_reg <= repeat_count_reg + 1'b1;
                        end
                        if (long_hit) begin
                            long_active_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_NOTIFY;
                end
                S_NOTIFY: begin
                    // advance only when the output register is free
                    if (out_free) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A debounce only ever runs after a real up or down level was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> (level_reg != LVL_POWERON))
        else $error("debounce pending in power-on state");

    // A release cannot be both a plain press and a long-press release
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.short_press && m_data.long_release))
        else $error("short press and long release together");

    // A repeat only fires while held with repeat on, so a next wait exists
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.repeat_fire) |-> (m_data.wait_ticks != NEVER_TICKS))
        else $error("repeat fired with no next wait");

    // Evaluation starts only with both serial results in hand
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL) |-> (mul_done && div_done))
        else $error("evaluation before serial units finished");

    // One sample in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sample accepted while another is in flight");

endmodule

/* tb/tb.sv */
// Self-checking testbench for button_debounce_repeat_longpress: drives pin samples
// and APB register writes, predicts every result and compares it as it arrives.
// Depends on bdrl_pkg and the button_debounce_repeat_longpress top level.
`timescale 1ns / 1ps

module tb import bdrl_pkg::*; ();

    localparam int LIMIT_CYCLES   = 600000;
    localparam int DRAIN_CYCLES   = 40;     // a bit more than the latency of one sample
    localparam int HOLD_OFF_LEN   = 400;
    localparam int REG_COUNT      = 5;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 172;
    localparam int NOISE_PCT      = 15;

    typedef enum logic [1:0] {
        BTN_POWERON = 2'd0,
        BTN_UP      = 2'd1,
        BTN_DOWN    = 2'd2
    } btn_level_e;

    // Tracks the button the way the block should, and holds the results it owes.
    class button_tracker;
        logic [PIN_W-1:0]  pin_mask;
        logic [TIME_W-1:0] debounce_time;
        logic [TIME_W-1:0] repeat_interval;
        logic [TIME_W-1:0] long_press_time;
        logic [EN_W-1:0]   enables;
        btn_level_e        level;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] repeat_count;
        logic              debounce_pending;
        logic              long_active;
        out_item_t         reports_due[$];
        int errors;
        int checked;
        int n_short, n_repeat, n_long_start, n_long_release;

        function new();
            pin_mask         = 8'h01;
            debounce_time    = 32'd50;
            repeat_interval  = NEVER_TICKS;
            long_press_time  = NEVER_TICKS;
            enables          = 3'b001;
            level            = BTN_POWERON;
            change_time      = '0;
            repeat_count     = '0;
            debounce_pending = 1'b0;
            long_active      = 1'b0;
            errors           = 0;
            checked          = 0;
            n_short          = 0;
            n_repeat         = 0;
            n_long_start     = 0;
            n_long_release   = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] value);
            case (idx)
                REG_PIN_MASK:   pin_mask        = PIN_W'(value);
                REG_DEBOUNCE:   debounce_time   = value;
                REG_REPEAT:     repeat_interval = value;
                REG_LONG_PRESS: long_press_time = value;
                REG_ENABLES:    enables         = EN_W'(value);
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(int idx);
            case (idx)
                REG_PIN_MASK:   return 32'(pin_mask);
                REG_DEBOUNCE:   return debounce_time;
                REG_REPEAT:     return repeat_interval;
                REG_LONG_PRESS: return long_press_time;
                REG_ENABLES:    return 32'(enables);
                default:        return '0;
            endcase
        endfunction

        // Level update, notify and next-wait, all in one sample.
        function out_item_t step_button(in_item_t it);
            out_item_t         r;
            btn_level_e        lvl;
            logic [TIME_W-1:0] now, delta, since_repeat;
            now = it.time_now[TIME_W-1:0];
            r   = '0;
            lvl = ((it.pin_levels & pin_mask & PIN_USED_MASK) != '0) ? BTN_DOWN : BTN_UP;
            // a release seen at power-on is no change
            if (!(lvl == level || (level == BTN_POWERON && lvl == BTN_UP))) begin
                level            = lvl;
                change_time      = now;
                debounce_pending = 1'b1;
            end

            delta = now - change_time;
            if (debounce_pending && delta >= debounce_time) begin
                debounce_pending = 1'b0;
                change_time      = now;
                if (level == BTN_DOWN) begin
                    long_active  = 1'b0;
                    repeat_count = '0;
                end else if (level == BTN_UP) begin
                    if (!long_active && repeat_count == '0 && enables[EN_SHORT])
                        r.short_press = 1'b1;
                    if (long_active && enables[EN_LONGUP])
                        r.long_release = 1'b1;
                end
            end else if (!debounce_pending && level == BTN_DOWN) begin
                since_repeat = delta - repeat_count * repeat_interval;
                if (repeat_interval != NEVER_TICKS && enables[EN_SHORT] &&
                    since_repeat >= repeat_interval) begin
                    r.repeat_fire = 1'b1;
                    repeat_count  = repeat_count + 1'b1;
                end
                if (long_press_time != NEVER_TICKS && delta >= long_press_time &&
                    !long_active && enables[EN_LONG]) begin
                    long_active  = 1'b1;
                    r.long_start = 1'b1;
                end
            end

            delta = now - change_time;
            if (debounce_pending)
                r.wait_ticks = (debounce_time > delta) ? debounce_time - delta : '0;
            else if (level == BTN_DOWN && repeat_interval != NEVER_TICKS)
                r.wait_ticks = (repeat_interval == '0) ? '0 :
                               repeat_interval - (delta % repeat_interval);
            else if (level == BTN_DOWN && !long_active && enables[EN_LONG] &&
                     long_press_time != NEVER_TICKS)
                r.wait_ticks = (long_press_time > delta) ? long_press_time - delta : '0;
            else
                r.wait_ticks = NEVER_TICKS;
            return r;
        endfunction

        function void record_sample(in_item_t it);
            out_item_t r;
            r = step_button(it);
            n_short        += r.short_press;
            n_repeat       += r.repeat_fire;
            n_long_start   += r.long_start;
            n_long_release += r.long_release;
            reports_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (reports_due.size() == 0) begin
                $display("%0t: result with nothing outstanding: expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = reports_due.pop_front();
            compare_field("short_press",  32'(want.short_press),  32'(got.short_press));
            compare_field("repeat_fire",  32'(want.repeat_fire),  32'(got.repeat_fire));
            compare_field("long_start",   32'(want.long_start),   32'(got.long_start));
            compare_field("long_release", 32'(want.long_release), 32'(got.long_release));
            compare_field("wait_ticks",   want.wait_ticks,        got.wait_ticks);
            checked++;
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ---------------------------------------------------------------------
    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    always #4 aclk = ~aclk;

    button_debounce_repeat_longpress uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    button_tracker tracker;

    // Stimulus-side copies of the settings, used to aim time steps at thresholds
    logic [PIN_W-1:0]  cfg_mask;
    logic [TIME_W-1:0] cfg_deb, cfg_rep, cfg_long;
    logic [TIME_W-1:0] cur_time;

    int idle_pct;          // chance per cycle that the sender holds off
    int stall_pct;         // chance per cycle that the receiver drops m_ready
    int hold_requests;     // bumped by the stimulus to ask for a long receiver hold-off
    int items_sent;
    int settings_used;
    int cycle_count;

    // ---------------------------------------------------------------------
    // Watchdog: end the run if it goes far past any correct duration
    // ---------------------------------------------------------------------
    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Result receiver: check each accepted transaction, then pick m_ready for
    // the next cycle. A hold-off request keeps m_ready low for a long stretch
    // so the block fills up and pushes back on the sample channel.
    // ---------------------------------------------------------------------
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                tracker.check_report(m_data);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_OFF_LEN;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sample driver
    // ---------------------------------------------------------------------

    // Advance the timestamp and offer one sample. The upper timestamp word is
    // random: the block ignores it, but every bit should still toggle.
    task automatic send_sample(logic [PIN_W-1:0] pins, logic [TIME_W-1:0] step);
        in_item_t it;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        cur_time      = cur_time + step;
        it.pin_levels = pins;
        it.time_now   = {32'($urandom()), cur_time};
        s_valid <= 1'b1;
        s_data  <= it;
        // hold valid and payload until the transaction is taken
        do @(posedge aclk); while (!s_ready);
        tracker.record_sample(it);
        items_sent++;
    endtask

    // Let every outstanding result come back before touching registers.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (tracker.reports_due.size() != 0)
            @(posedge aclk);
    endtask

    // APB write in setup + access cycles, then read the register back when it exists.
    task automatic write_reg(int idx, logic [31:0] value);
        logic [APB_DW-1:0] rd;
        logic [APB_DW-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_reg(idx, value);
        if (idx < REG_COUNT) begin
            pwrite  <= 1'b0;
            penable <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            rd   = prdata;
            want = tracker.reg_value(idx);
            if (rd !== want) begin
                $display("%0t: register %0d readback mismatch: expected %0h, actual %0h",
                         $time, idx, want, rd);
                tracker.errors++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return the bus to idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic set_button_config(logic [31:0] mask, logic [31:0] deb,
                                     logic [31:0] rep, logic [31:0] long_t,
                                     logic [31:0] en);
        write_reg(REG_PIN_MASK, mask);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_REPEAT, rep);
        write_reg(REG_LONG_PRESS, long_t);
        write_reg(REG_ENABLES, en);
        cfg_mask = PIN_W'(mask);
        cfg_deb  = deb;
        cfg_rep  = rep;
        cfg_long = long_t;
        settings_used++;
    endtask

    // One below, on or one above a threshold (wrapping).
    function automatic logic [TIME_W-1:0] near_value(logic [TIME_W-1:0] v);
        return v + TIME_W'($urandom_range(0, 2)) - 1'b1;
    endfunction

    // Time step aimed mostly at the debounce, repeat and long-press edges.
    function automatic logic [TIME_W-1:0] pick_step();
        case ($urandom_range(0, 11))
            0:       return '0;
            1, 2:    return TIME_W'($urandom_range(1, 16));
            3, 4:    return near_value(cfg_deb);
            5, 6:    return near_value(cfg_rep);
            7, 8:    return near_value(cfg_long);
            9:       return TIME_W'($urandom_range(0, 255));
            10:      return near_value(cfg_rep + cfg_rep);
            default: return TIME_W'($urandom());
        endcase
    endfunction

    // Pin pattern with at least one of the button's pins high (when it has any).
    function automatic logic [PIN_W-1:0] down_pins();
        logic [PIN_W-1:0] m;
        logic [PIN_W-1:0] p;
        m = cfg_mask & PIN_USED_MASK;
        p = PIN_W'($urandom_range(0, 255));
        if ((p & m) == '0)
            p = p | (m & (~m + 1'b1));
        return p;
    endfunction

    function automatic logic [PIN_W-1:0] up_pins();
        return PIN_W'($urandom_range(0, 255)) & ~(cfg_mask & PIN_USED_MASK);
    endfunction

    // Press, optional bounce, hold through a few samples, release and settle.
    task automatic press_sequence();
        int holds;
        send_sample(down_pins(), TIME_W'($urandom_range(0, 8)));
        if ($urandom_range(0, 3) == 0) begin
            send_sample(up_pins(), TIME_W'($urandom_range(0, 4)));
            send_sample(down_pins(), TIME_W'($urandom_range(0, 4)));
        end
        holds = $urandom_range(1, 8);
        repeat (holds) send_sample(down_pins(), pick_step());
        send_sample(up_pins(), TIME_W'($urandom_range(0, 8)));
        repeat ($urandom_range(1, 3)) send_sample(up_pins(), pick_step());
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        int ph;
        int phase_start;
        tracker       = new();
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        items_sent    = 0;
        settings_used = 1;
        cur_time      = '0;
        cfg_mask      = 8'h01;
        cfg_deb       = 32'd50;
        cfg_rep       = NEVER_TICKS;
        cfg_long      = NEVER_TICKS;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: defaults after reset (mask 1, debounce 50, no repeat, no long)
        send_sample(8'h00, 32'd0);       // release at power-on is no change
        send_sample(8'hFE, 32'd10);      // pins outside the mask stay up
        send_sample(8'h01, 32'd5);       // press starts a debounce
        send_sample(8'h01, 32'd50);      // debounce completes the press
        send_sample(8'hFF, 32'd1000);    // held, nothing due
        send_sample(8'h00, 32'd3);       // release starts a debounce
        send_sample(8'h00, 32'd49);      // one tick short
        send_sample(8'h00, 32'd1);       // settles: plain press
        drain_results();

        // Extremes: every pin, zero debounce, zero repeat interval, zero hold time
        set_button_config(32'h0000_00FF, 32'd0, 32'd0, 32'd0, 32'd7);
        send_sample(8'h80, 32'd1);       // press settles at once
        send_sample(8'h80, 32'd0);       // repeat on every sample plus long start
        send_sample(8'h40, 32'd0);
        send_sample(8'h00, 32'd1);       // release after a long press
        drain_results();

        // Mask with junk above bit 7, writes to unused indexes, timestamp wrap
        set_button_config(32'hFFFF_FF5A, 32'd2, 32'hFFFF_FFFE, NEVER_TICKS, 32'd4);
        write_reg(REG_COUNT, 32'hDEAD_BEEF);
        write_reg(REG_COUNT + 2, 32'h0000_0000);
        cur_time = 32'hFFFF_FFF0;
        send_sample(8'h02, 32'd14);      // press just before the wrap
        send_sample(8'h02, 32'd4);       // settles across the wrap
        send_sample(8'hA5, 32'd1);       // no masked pin high: release
        send_sample(8'hA5, 32'd2);
        drain_results();

        // Longest debounce, shortest repeat, long press never
        set_button_config(32'h0000_00FF, NEVER_TICKS, 32'd1, NEVER_TICKS, 32'd3);
        send_sample(8'h01, 32'd1);
        send_sample(8'h01, 32'hFFFF_FFFE);   // elapsed reaches 32'hFFFF_FFFE
        send_sample(8'h01, 32'd3);           // one repeat per sample at most
        send_sample(8'h00, 32'd5);
        drain_results();

        // Random phases: a different setting in each, and one of four idling patterns
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: set_button_config(32'h01, 32'd10, 32'd25, 32'd80, 32'd7);
                1: set_button_config(32'hFF, 32'd0, 32'd0, 32'd0, 32'd7);
                2: set_button_config(32'h00, 32'd5, 32'd20, 32'd30, 32'd7);
                3: set_button_config(32'hA5, 32'd20, NEVER_TICKS, 32'd60, 32'd3);
                4: set_button_config(32'h5A, 32'd3, 32'd7, NEVER_TICKS, 32'd5);
                5: set_button_config($urandom_range(0, 255), $urandom_range(0, 40),
                                     $urandom_range(1, 50), $urandom_range(0, 120),
                                     $urandom_range(0, 7));
                6: set_button_config(32'h80, NEVER_TICKS, 32'hFFFF_FFFE,
                                     32'hFFFF_FFFE, 32'd7);
                default: set_button_config(32'h3C, 32'd15, 32'd1, 32'd40, 32'd0);
            endcase
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 51; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 9;  stall_pct = 9;  end
            endcase
            // back-pressure: the receiver stops while samples keep coming
            if (ph == 0)
                hold_requests++;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < NOISE_PCT)
                    send_sample(PIN_W'($urandom_range(0, 255)), pick_step());
                else
                    press_sequence();
            end
            drain_results();
        end

        // Let any stray result show up before judging
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d samples checked under %0d register settings", tracker.checked,
                 settings_used);
        $display("tb: events seen: %0d short, %0d repeat, %0d long start, %0d long release",
                 tracker.n_short, tracker.n_repeat, tracker.n_long_start,
                 tracker.n_long_release);
        if (tracker.errors == 0 && tracker.reports_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0t: %0d errors, %0d results still outstanding", $time,
                     tracker.errors, tracker.reports_due.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
